// File: rtl/slug_pkg.sv
// Shared constants, types and table write port for the shuffled LCG generator.
`timescale 1ns / 1ps

package slug_pkg;

   // Word and table geometry
   localparam int WORD_W       = 31;
   localparam int TABLE_DEPTH  = 32;
   localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WARMUP_STEPS = 8;
   localparam int STEP_COUNT   = TABLE_DEPTH + WARMUP_STEPS;
   localparam int STEP_W       = $clog2(STEP_COUNT);

   // Generator: seed' = LCG_MUL * seed mod LCG_MOD
   localparam int MUL_W  = 17;
   localparam int PROD_W = WORD_W + MUL_W;
   localparam logic [WORD_W-1:0] LCG_MOD = 31'h7fff_ffff;
   localparam logic [MUL_W-1:0]  LCG_MUL = 17'h1_0ff5;

   // Entry select: index / SEL_DIV by reciprocal multiply and one correction
   localparam longint SEL_DIV    = 64'd1 + (longint'(LCG_MOD) - 64'd1) / TABLE_DEPTH;
   localparam int     SEL_SHIFT  = WORD_W + IDX_W;
   localparam int     SEL_Q_W    = IDX_W + 1;
   localparam int     SEL_PROD_W = SEL_SHIFT + SEL_Q_W;
   localparam longint SEL_RECIP  = ((64'd1 << SEL_SHIFT) + SEL_DIV - 64'd1) / SEL_DIV;
   localparam int     SEL_CHK_W  = SEL_Q_W + WORD_W;

   // Item modes
   localparam logic MODE_DRAW   = 1'b0;
   localparam logic MODE_RESEED = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [STEP_W-1:0] step_type;

   // Write port of the shuffle table
   typedef struct packed {
      logic     en;
      idx_type  addr;
      word_type data;
   } tbl_wr_type;

endpackage

// File: rtl/slug_lcg_step.sv
// One generator step: registered multiply, then fold modulo 2^31-1.
`timescale 1ns / 1ps

module slug_lcg_step (
   input  logic              clock,
   input  slug_pkg::word_type seed,
   output slug_pkg::word_type next_seed
);
   import slug_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [MUL_W-1:0]  prod_hi;
   word_type          prod_lo;
   logic [WORD_W:0]   fold_sum;
   logic [WORD_W:0]   fold_sub;

   // Multiply the current seed by the generator constant
   assign prod_in = PROD_W'(LCG_MUL) * PROD_W'(seed);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Fold: 2^31 is 1 modulo 2^31-1, so add the high part to the low part
   assign prod_hi  = prod_ff[PROD_W-1:WORD_W];
   assign prod_lo  = prod_ff[WORD_W-1:0];
   assign fold_sum = {1'b0, prod_lo} + (WORD_W+1)'(prod_hi);
   assign fold_sub = fold_sum - {1'b0, LCG_MOD};

   // One conditional subtract brings the sum below the modulus
   always_comb begin
      if (fold_sum >= {1'b0, LCG_MOD}) begin
         next_seed = fold_sub[WORD_W-1:0];
      end else begin
         next_seed = fold_sum[WORD_W-1:0];
      end
   end

endmodule

// File: rtl/slug_sel.sv
// Table entry select: index word divided by the bucket size, saturated.
`timescale 1ns / 1ps

module slug_sel (
   input  logic               clock,
   input  slug_pkg::word_type index_word,
   output slug_pkg::idx_type  sel
);
   import slug_pkg::*;

   logic [SEL_PROD_W-1:0] prod_ff;
   word_type              index_ff;
   logic [SEL_Q_W-1:0]    q_est;
   logic [SEL_CHK_W-1:0]  chk;
   logic [SEL_Q_W-1:0]    q_fix;

   // Estimate the quotient with a rounded-up reciprocal
   always_ff @(posedge clock) begin
      prod_ff  <= SEL_PROD_W'(index_word) * SEL_PROD_W'(SEL_RECIP);
      index_ff <= index_word;
   end

   assign q_est = prod_ff[SEL_SHIFT +: SEL_Q_W];
   assign chk   = SEL_CHK_W'(q_est) * SEL_CHK_W'(SEL_DIV);

   // Estimate is exact or one too high: back off when it overshoots
   always_comb begin
      if (chk > SEL_CHK_W'(index_ff)) begin
         q_fix = q_est - SEL_Q_W'(1);
      end else begin
         q_fix = q_est;
      end
   end

   // Clamp to the last entry
   always_comb begin
      if (q_fix >= SEL_Q_W'(TABLE_DEPTH)) begin
         sel = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         sel = q_fix[IDX_W-1:0];
      end
   end

endmodule

// File: rtl/slug_table.sv
// Shuffle table memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module slug_table (
   input  logic                 clock,
   input  logic                 reset,
   input  slug_pkg::tbl_wr_type wr,
   input  logic                 rd_en,
   input  slug_pkg::idx_type    rd_addr,
   output slug_pkg::word_type   rd_data
);
   import slug_pkg::*;

   word_type                   mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]     valid_ff;
   word_type                   rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Mark written entries; reset makes every entry read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Registered read; hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem_ff[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/shuffled_lcg_uniform_generator_core.sv
// Top level of the shuffled LCG uniform generator: control, state registers, result register.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_mode, req_seed_value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_random_word
//
// A draw passes through the idle state that accepts it, a state that launches the registered
// table read, and the write-back state; its result is registered when the write-back completes.
// A reseed runs TABLE_DEPTH + 8 generator steps, each a registered multiply state then a
// fold state, and gives no result.
// Synchronous reset clears seed, index word and all table valid bits.
// A stalled result holds a following draw in write-back until the result is taken.
`timescale 1ns / 1ps

module shuffled_lcg_uniform_generator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  slug_pkg::word_type req_seed_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output slug_pkg::word_type rsp_random_word
);
   import slug_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DRAW_MUL  = 3'd1;
   localparam logic [2:0] S_DRAW_WB   = 3'd2;
   localparam logic [2:0] S_SEED_MUL  = 3'd3;
   localparam logic [2:0] S_SEED_FOLD = 3'd4;

   logic [2:0] state_ff, state_in;
   word_type   seed_ff, seed_in;
   word_type   index_ff, index_in;
   step_type   step_cnt_ff, step_cnt_in;
   idx_type    sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_word_ff, rsp_word_in;

   word_type   next_seed;
   idx_type    sel;
   word_type   rd_data;
   logic       rd_en;
   tbl_wr_type tbl_wr;
   logic       req_accept;
   logic       rsp_blocked;

   slug_lcg_step u_lcg_step (
      .clock     (clock),
      .seed      (seed_ff),
      .next_seed (next_seed)
   );

   slug_sel u_sel (
      .clock      (clock),
      .index_word (index_ff),
      .sel        (sel)
   );

   slug_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_en   (rd_en),
      .rd_addr (sel),
      .rd_data (rd_data)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_blocked = rsp_valid_ff && rsp_stall;
   assign rd_en       = (state_ff == S_DRAW_MUL);

   // Sequence draws and reseeds
   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      index_in     = index_ff;
      step_cnt_in  = step_cnt_ff;
      sel_in       = sel_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tbl_wr.en    = 1'b0;
      tbl_wr.addr  = sel_ff;
      tbl_wr.data  = seed_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_RESEED) begin
                  seed_in     = req_seed_value;
                  step_cnt_in = STEP_W'(STEP_COUNT - 1);
                  state_in    = S_SEED_MUL;
               end else begin
                  state_in = S_DRAW_MUL;
               end
            end
         end
         S_DRAW_MUL: begin
            // advance the seed, launch the table read
            seed_in  = next_seed;
            sel_in   = sel;
            state_in = S_DRAW_WB;
         end
         S_DRAW_WB: begin
            // swap: old entry out, new seed in
            if (!rsp_blocked) begin
               tbl_wr.en    = 1'b1;
               index_in     = rd_data;
               rsp_word_in  = rd_data;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SEED_MUL: begin
            state_in = S_SEED_FOLD;
         end
         S_SEED_FOLD: begin
            // fill the table top down during the last steps
            seed_in     = next_seed;
            tbl_wr.addr = step_cnt_ff[IDX_W-1:0];
            tbl_wr.data = next_seed;
            tbl_wr.en   = (step_cnt_ff < STEP_W'(TABLE_DEPTH));
            if (step_cnt_ff == '0) begin
               index_in = next_seed;
               state_in = S_IDLE;
            end else begin
               step_cnt_in = step_cnt_ff - STEP_W'(1);
               state_in    = S_SEED_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= '0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         step_cnt_ff  <= step_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   // Entry select stays inside the table
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAW_MUL) |-> (32'(sel) < TABLE_DEPTH))
      else $error("entry select out of range");

   // Outputs are always reduced modulo 2^31-1
   a_word_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff != LCG_MOD))
      else $error("result not reduced");

   // Only a draw's write-back raises a result
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DRAW_WB))
      else $error("result raised outside a draw");

   // An unblocked write-back completes the draw and shows the result
   a_draw_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAW_WB && !rsp_blocked) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("draw did not complete");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the shuffled LCG uniform generator core.
`timescale 1ns / 1ps

module tb;
   import slug_pkg::*;

   localparam longint unsigned SEL_DIVISOR =
      1 + (longint'(31'h7fff_ffff) - 1) / TABLE_DEPTH;
   localparam int N_RANDOM     = 530;
   localparam int HOLD_CYCLES  = 250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 120;

   typedef struct {
      bit       drain;
      bit       steady;
      bit       hold_rsp;
      bit       mode;
      word_type seed;
   } gen_item_type;

   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     req_valid      = 1'b0;
   logic     req_stall;
   logic     req_mode       = MODE_DRAW;
   word_type req_seed_value = '0;
   logic     rsp_valid;
   logic     rsp_stall      = 1'b0;
   word_type rsp_random_word;

   // generator state as predicted from accepted items; starts cleared like the block
   word_type gen_seed  = '0;
   word_type last_word = '0;
   word_type shuffle_tbl [TABLE_DEPTH] = '{default: '0};

   gen_item_type pending_items [$];
   word_type     expected_words [$];

   logic     steady_phase = 1'b0;
   int       hold_token   = 0;
   int       hold_seen    = 0;
   int       hold_left    = 0;
   int       draws_sent   = 0;
   int       reseeds_sent = 0;
   int       words_checked = 0;
   int       error_count  = 0;

   shuffled_lcg_uniform_generator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_seed_value  (req_seed_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_random_word (rsp_random_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one generator step: exact product mod 2^31-1
   function automatic word_type lcg_next(word_type s);
      logic [63:0] prod;
      prod = 64'(LCG_MUL) * 64'(s);
      prod = prod % 64'(LCG_MOD);
      return prod[WORD_W-1:0];
   endfunction

   // load the seed, warm up, then fill the table from the top entry down
   task automatic apply_reseed(input word_type seed);
      gen_seed = seed;
      for (int n = TABLE_DEPTH + WARMUP_STEPS - 1; n >= 0; n--) begin
         gen_seed = lcg_next(gen_seed);
         if (n < TABLE_DEPTH) shuffle_tbl[n] = gen_seed;
      end
      last_word = shuffle_tbl[0];
   endtask

   // step the seed, swap it into the selected entry, return the old entry
   function automatic word_type draw_next();
      longint unsigned sel;
      gen_seed = lcg_next(gen_seed);
      sel = longint'(last_word) / SEL_DIVISOR;
      if (sel >= TABLE_DEPTH) sel = TABLE_DEPTH - 1;
      last_word = shuffle_tbl[sel];
      shuffle_tbl[sel] = gen_seed;
      return last_word;
   endfunction

   function automatic void add_item(bit mode, word_type seed, bit steady = 1'b0,
                                    bit hold_rsp = 1'b0);
      gen_item_type it;
      it.drain    = 1'b0;
      it.steady   = steady;
      it.hold_rsp = hold_rsp;
      it.mode     = mode;
      it.seed     = seed;
      pending_items.push_back(it);
   endfunction

   function automatic void add_drain();
      gen_item_type it;
      it = '{drain: 1'b1, steady: 1'b0, hold_rsp: 1'b0, mode: MODE_DRAW, seed: '0};
      pending_items.push_back(it);
   endfunction

   // driver: retire accepted items into the predictor, offer the next one
   always @(posedge clock) begin
      gen_item_type it;
      logic         next_valid;
      logic         next_mode;
      word_type     next_seed;
      logic         next_steady;
      if (reset) begin
         req_valid      <= 1'b0;
         req_mode       <= MODE_DRAW;
         req_seed_value <= '0;
         steady_phase   <= 1'b0;
      end else begin
         next_valid  = req_valid;
         next_mode   = req_mode;
         next_seed   = req_seed_value;
         next_steady = steady_phase;
         if (req_valid && !req_stall) begin
            if (req_mode == MODE_RESEED) begin
               apply_reseed(req_seed_value);
               reseeds_sent++;
            end else begin
               expected_words.push_back(draw_next());
               draws_sent++;
            end
            next_valid = 1'b0;
         end
         if (!next_valid && pending_items.size() > 0) begin
            if (pending_items[0].drain) begin
               // hold until every outstanding word has come back
               if (expected_words.size() == 0) void'(pending_items.pop_front());
            end else if (steady_phase || $urandom_range(99) >= 20) begin
               it          = pending_items.pop_front();
               next_valid  = 1'b1;
               next_mode   = it.mode;
               next_seed   = it.seed;
               next_steady = it.steady;
               if (it.hold_rsp) hold_token <= hold_token + 1;
            end
         end
         req_valid      <= next_valid;
         req_mode       <= next_mode;
         req_seed_value <= next_seed;
         steady_phase   <= next_steady;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_phase && ($urandom_range(99) < 20);
      end
   end

   // monitor: compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("random_word: no result expected, actual %0d", rsp_random_word);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_random_word !== want) begin
               $error("random_word mismatch: expected %0d, actual %0d", want, rsp_random_word);
               error_count++;
            end
         end
      end
   end

   // watchdog: end the run if nothing moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      bit       mode;
      word_type seed;
      int       pick;
      // draws on the cleared state return zero
      repeat (3) add_item(MODE_DRAW, '0);
      // zero seed stays zero
      add_item(MODE_RESEED, '0);
      repeat (2) add_item(MODE_DRAW, '0);
      // all-ones seed folds to zero on the first step
      add_item(MODE_RESEED, 31'h7fff_ffff);
      repeat (2) add_item(MODE_DRAW, '0);
      add_item(MODE_RESEED, 31'd1);
      repeat (3) add_item(MODE_DRAW, '0);
      add_item(MODE_RESEED, 31'h7fff_fffe);
      repeat (3) add_item(MODE_DRAW, '0);
      add_item(MODE_RESEED, 31'h5555_5555);
      add_item(MODE_DRAW, '0);
      add_item(MODE_RESEED, 31'h2aaa_aaaa);
      add_item(MODE_DRAW, 31'h7fff_ffff);
      // reseed between two draws
      add_item(MODE_RESEED, 31'd123456789);
      add_item(MODE_DRAW, 31'h7fff_ffff);
      add_drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         mode = ($urandom_range(99) < 7) ? MODE_RESEED : MODE_DRAW;
         if (i >= 60 && i < 76) mode = MODE_DRAW;
         seed = word_type'($urandom);
         if (mode == MODE_RESEED && $urandom_range(15) == 0) begin
            pick = $urandom_range(3);
            case (pick)
               0: seed = '0;
               1: seed = 31'd1;
               2: seed = 31'h7fff_fffe;
               default: seed = 31'h7fff_ffff;
            endcase
         end
         add_item(mode, seed, (i >= 250 && i < 350), (i == 60));
         if (i == 150 || i == 400) add_drain();
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d draws and %0d reseeds (extreme seeds, long output hold-off,",
               draws_sent, reseeds_sent);
      $display("drained pauses); %0d words checked, %0d errors", words_checked, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
